### sv/burst_header_pairing_table_defines.svh
// Assertion macros for the checker file of the pairing table.
`ifndef BURST_HEADER_PAIRING_TABLE_DEFINES_SVH
`define BURST_HEADER_PAIRING_TABLE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BHPT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BHPT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BHPT_CHECK_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bhpt_pkg.sv
package bhpt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(TABLE_DEPTH - 1);

  // Action codes carried by an input item.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_END = 1'b1;

  // Saturation bounds of the 48-bit signed offset.
  localparam logic signed [47:0] DELTA_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] DELTA_MIN = {1'b1, {47{1'b0}}};
  localparam logic [47:0] TIME_MAX = {48{1'b1}};

  typedef struct packed {
    logic               action;
    logic [15:0]        source_id;
    logic [31:0]        seq_num;
    logic [5:0]         in_port;
    logic signed [47:0] burst_delta;
    logic [47:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        source_id_out;
    logic [31:0]        seq_num_out;
    logic [5:0]         port_out;
    logic signed [47:0] adjusted_delta;
    logic [47:0]        release_time;
  } out_item_t;

  // One table entry. The base holds the begin offset plus its arrival time.
  typedef struct packed {
    logic [15:0]        source;
    logic [31:0]        seq;
    logic signed [49:0] base;
    logic [31:0]        stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### sv/burst_header_pairing_table.sv
// Burst header pairing table.
// Input channel (in_valid, in_ready, in_item): a begin item stores its header in the
// lowest free slot and gives no result; it is dropped when the table is full.
// An end item scans the table one slot per cycle through the entry memory read port,
// picks the oldest matching entry, frees it and returns one result on the output
// channel (out_valid, out_ready, out_item). An end item without a match gives nothing.
// A begin item never holds in_ready low. An end item holds in_ready low while it scans
// all TABLE_DEPTH slots and until the block is idle again; the scan length is set
// by the single memory read port.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes conversion_delay and is
// always ready; write it only while the block is idle.
// Reset clears all slot valid bits, the insertion counter and conversion_delay; the
// entry memory needs no clearing. A result waits in the output register while the
// receiver stalls; the next end item then finishes its scan and waits for that slot.
module burst_header_pairing_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bhpt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bhpt_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import bhpt_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [31:0]            conversion_delay;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [31:0]            insert_counter;
  logic [IDX_W-1:0]       scan_idx;

  logic [15:0]            key_source;
  logic [31:0]            key_seq;
  logic [5:0]             key_port;
  logic [48:0]            key_due;

  logic                   best_found;
  logic [IDX_W-1:0]       best_idx;
  logic [31:0]            best_age;
  logic signed [49:0]     best_base;
  logic [15:0]            best_source;
  logic [31:0]            best_seq;

  logic                   in_fire;
  logic                   begin_fire;
  logic                   end_fire;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   ram_we;
  entry_t                 wr_entry;
  entry_t                 rd_entry;
  logic [IDX_W-1:0]       rd_addr;
  logic                   hit;
  logic [31:0]            age;
  logic                   take;
  logic                   out_free;
  logic                   load_out;
  logic [50:0]            diff;
  logic signed [47:0]     adj_sat;
  logic [47:0]            rel_sat;

  // Handshake decode.
  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_valid && in_ready;
  assign begin_fire = in_fire && (in_item.action == ACT_BEGIN);
  assign end_fire   = in_fire && (in_item.action == ACT_END);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Entry written by a begin item.
  assign ram_we            = begin_fire && free_found;
  assign wr_entry.source   = in_item.source_id;
  assign wr_entry.seq      = in_item.seq_num;
  assign wr_entry.base     = {{2{in_item.burst_delta[47]}}, in_item.burst_delta}
                           + {2'b00, in_item.now_time};
  assign wr_entry.stamp    = insert_counter;

  // The scan reads slot zero on the end transfer, then one slot ahead of the compare.
  assign rd_addr = (state == ST_IDLE) ? '0 : scan_idx + IDX_W'(1);

  bhpt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(wr_entry),
    .raddr(rd_addr),
    .rdata(rd_entry)
  );

  // Compare the entry read for scan_idx and keep the oldest match.
  assign hit  = slot_valid[scan_idx] && (rd_entry.source == key_source)
             && (rd_entry.seq == key_seq);
  assign age  = insert_counter - rd_entry.stamp;
  assign take = (state == ST_SCAN) && hit && (!best_found || (age > best_age));

  // Result arithmetic with saturation.
  assign diff = {best_base[49], best_base} - {2'b00, key_due};
  always_comb begin
    if ((diff[50:47] == 4'b0000) || (diff[50:47] == 4'b1111)) begin
      adj_sat = diff[47:0];
    end else if (diff[50]) begin
      adj_sat = DELTA_MIN;
    end else begin
      adj_sat = DELTA_MAX;
    end
  end
  assign rel_sat  = key_due[48] ? TIME_MAX : key_due[47:0];

  assign out_free = !out_valid || out_ready;
  assign load_out = (state == ST_DONE) && best_found && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (end_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == SCAN_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!best_found || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      conversion_delay <= '0;
      slot_valid       <= '0;
      insert_counter   <= '0;
      scan_idx         <= '0;
      best_found       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        conversion_delay <= cfg_data;
      end
      if (ram_we) begin
        slot_valid[free_idx] <= 1'b1;
        insert_counter       <= insert_counter + 32'd1;
      end
      if (end_fire) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (take) begin
          best_found <= 1'b1;
        end
      end
      if (load_out) begin
        slot_valid[best_idx] <= 1'b0;
        out_valid            <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (end_fire) begin
      key_source <= in_item.source_id;
      key_seq    <= in_item.seq_num;
      key_port   <= in_item.in_port;
      key_due    <= {1'b0, in_item.now_time} + {17'd0, conversion_delay};
    end
    if (take) begin
      best_idx    <= scan_idx;
      best_age    <= age;
      best_base   <= rd_entry.base;
      best_source <= rd_entry.source;
      best_seq    <= rd_entry.seq;
    end
    if (load_out) begin
      out_item.source_id_out  <= best_source;
      out_item.seq_num_out    <= best_seq;
      out_item.port_out       <= key_port;
      out_item.adjusted_delta <= adj_sat;
      out_item.release_time   <= rel_sat;
    end
  end

endmodule

### sv/bhpt_ram.sv
module bhpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bhpt_checker.sv
`include "burst_header_pairing_table_defines.svh"

module bhpt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bhpt_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input bhpt_pkg::out_item_t out_item
);
  import bhpt_pkg::*;

  logic out_stall;
  logic begin_fire;
  logic end_fire;

  // Transfers and stalls seen at the ports.
  assign out_stall  = out_valid && !out_ready;
  assign begin_fire = in_valid && in_ready && (in_item.action == ACT_BEGIN);
  assign end_fire   = in_valid && in_ready && (in_item.action == ACT_END);

  // A stalled result stays and holds its value.
  `BHPT_CHECK_NEXT(a_out_hold, out_stall, out_valid && $stable(out_item), "stalled result changed")

  // Reset leaves the block idle with no result pending.
  `BHPT_CHECK_ALWAYS(a_reset_idle, rst, !out_valid && in_ready, "not idle after reset")

  // A begin transfer into an empty output never produces a result.
  `BHPT_CHECK_NEXT(a_begin_silent, begin_fire && !out_valid, !out_valid, "begin gave a result")

  // An end transfer starts a table scan, so the input is busy next cycle.
  `BHPT_CHECK_NEXT(a_end_busy, end_fire, !in_ready, "input ready during scan")

endmodule

bind burst_header_pairing_table bhpt_checker u_bhpt_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bhpt_pkg::*;

  // An end transfer scans every slot before it answers; this covers one scan.
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_PRINTED = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] cfg_value;
    in_item_t    item;
    bit          fixed;
    out_item_t   fixed_out;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the pairing table and its register.
  bit                 tbl_valid [TABLE_DEPTH];
  logic [15:0]        tbl_source [TABLE_DEPTH];
  logic [31:0]        tbl_seq [TABLE_DEPTH];
  logic [47:0]        tbl_arrival [TABLE_DEPTH];
  logic signed [47:0] tbl_delta [TABLE_DEPTH];
  logic [31:0]        tbl_stamp [TABLE_DEPTH];
  logic [31:0]        tbl_counter = '0;
  logic [31:0]        delay_model = '0;

  out_item_t pending_results[$];
  out_item_t exp_res;
  stim_row_t directed_rows[$];

  int  error_count = 0;
  int  begins_sent = 0;
  int  ends_sent = 0;
  int  drops_seen = 0;
  int  unmatched_seen = 0;
  int  pairs_checked = 0;
  int  delays_written = 0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_stalls_on = 1'b0;
  int  rx_stall_left = 0;
  logic [47:0] timebase = '0;

  burst_header_pairing_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Appends one row to the directed table.
  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Applies one header to the shadow table; returns 1 when it pairs.
  function automatic bit pair_header(input in_item_t it, output out_item_t res);
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    longint      adj;
    logic [48:0] rel;
    best = -1;
    best_age = '0;
    res = '0;
    if (it.action == ACT_BEGIN) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (!tbl_valid[k]) begin
          tbl_valid[k] = 1'b1;
          tbl_source[k] = it.source_id;
          tbl_seq[k] = it.seq_num;
          tbl_arrival[k] = it.now_time;
          tbl_delta[k] = it.burst_delta;
          tbl_stamp[k] = tbl_counter;
          tbl_counter = tbl_counter + 32'd1;
          return 1'b0;
        end
      end
      drops_seen++;
      return 1'b0;
    end
    // The oldest match wins; age is taken modulo 2^32.
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (tbl_valid[k] && tbl_source[k] == it.source_id && tbl_seq[k] == it.seq_num) begin
        age = tbl_counter - tbl_stamp[k];
        if (best < 0 || age > best_age) begin
          best = k;
          best_age = age;
        end
      end
    end
    if (best < 0) begin
      unmatched_seen++;
      return 1'b0;
    end
    tbl_valid[best] = 1'b0;
    adj = longint'($signed(tbl_delta[best]))
          - (longint'({16'd0, it.now_time}) - longint'({16'd0, tbl_arrival[best]}))
          - longint'({32'd0, delay_model});
    if (adj > longint'(DELTA_MAX)) adj = longint'(DELTA_MAX);
    if (adj < longint'(DELTA_MIN)) adj = longint'(DELTA_MIN);
    rel = {1'b0, it.now_time} + {17'd0, delay_model};
    res.source_id_out = tbl_source[best];
    res.seq_num_out = tbl_seq[best];
    res.port_out = it.in_port;
    res.adjusted_delta = adj[47:0];
    res.release_time = rel[48] ? TIME_MAX : rel[47:0];
    return 1'b1;
  endfunction

  function automatic logic [47:0] rnd48();
    return {16'($urandom_range(0, 65535)), $urandom};
  endfunction

  function automatic stim_row_t begin_row(input logic [15:0] src, input logic [31:0] seq,
                                          input logic signed [47:0] delta,
                                          input logic [47:0] now);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.cfg_value = '0;
    r.item = '0;
    r.item.action = ACT_BEGIN;
    r.item.source_id = src;
    r.item.seq_num = seq;
    r.item.burst_delta = delta;
    r.item.now_time = now;
    r.fixed = 1'b0;
    r.fixed_out = '0;
    return r;
  endfunction

  function automatic stim_row_t end_row(input logic [15:0] src, input logic [31:0] seq,
                                        input logic [5:0] port, input logic [47:0] now);
    stim_row_t r;
    r = begin_row(src, seq, '0, now);
    r.item.action = ACT_END;
    r.item.in_port = port;
    return r;
  endfunction

  // Attaches a result that can be read off directly.
  function automatic stim_row_t paired(input stim_row_t r, input logic signed [47:0] adj,
                                       input logic [47:0] rel);
    r.fixed = 1'b1;
    r.fixed_out.source_id_out = r.item.source_id;
    r.fixed_out.seq_num_out = r.item.seq_num;
    r.fixed_out.port_out = r.item.in_port;
    r.fixed_out.adjusted_delta = adj;
    r.fixed_out.release_time = rel;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [31:0] value);
    stim_row_t r;
    r = begin_row('0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.cfg_value = value;
    return r;
  endfunction

  // Drives one header and records what it should produce once it transfers.
  task automatic send_header(input in_item_t it, input bit fixed, input out_item_t fixed_out);
    out_item_t res;
    bit        hit;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    hit = pair_header(it, res);
    if (it.action == ACT_BEGIN) begins_sent++;
    else ends_sent++;
    if (fixed) pending_results.insert(pending_results.size(), fixed_out);
    else if (hit) pending_results.insert(pending_results.size(), res);
  endtask

  // Random gap after a transfer while gaps are on: mostly none, sometimes short, rarely long.
  task automatic sender_pause();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the input until every pending result is out and any scan has ended.
  task automatic drain_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delay(input logic [31:0] value);
    drain_table();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    delay_model = value;
    delays_written++;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_header(input int begin_pct, output in_item_t it);
    int live[$];
    int pick;
    it = '0;
    timebase = timebase + 48'($urandom_range(0, 3000));
    it.in_port = 6'($urandom_range(0, 63));
    it.now_time = ($urandom_range(0, 99) < 90) ? timebase : rnd48();
    if ($urandom_range(0, 99) < begin_pct) begin
      it.action = ACT_BEGIN;
      // A small id pool makes repeated pairs and oldest-first picks likely.
      it.source_id = ($urandom_range(0, 99) < 40) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      it.seq_num = ($urandom_range(0, 99) < 40) ? 32'($urandom_range(0, 3)) : $urandom;
      case ($urandom_range(0, 9))
        0:       it.burst_delta = DELTA_MAX;
        1:       it.burst_delta = DELTA_MIN;
        2:       it.burst_delta = rnd48();
        default: it.burst_delta = 48'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
    end else begin
      it.action = ACT_END;
      it.burst_delta = rnd48();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (tbl_valid[k]) live.insert(live.size(), k);
      end
      if (live.size() != 0 && $urandom_range(0, 99) < 80) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        it.source_id = tbl_source[pick];
        it.seq_num = tbl_seq[pick];
      end else begin
        it.source_id = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        it.seq_num = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 3)) : $urandom;
      end
    end
  endtask

  // Receiver: ready most of the time, with short and occasional long stalls.
  always @(posedge clk) begin
    if (!rx_stalls_on) begin
      out_ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_ready <= 1'b0;
          rx_stall_left = $urandom_range(0, 2);
        end
        4: begin
          out_ready <= 1'b0;
          rx_stall_left = $urandom_range(20, 60);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Result checker: each transfer against the oldest pending result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result src=%h seq=%h",
                                  out_item.source_id_out, out_item.seq_num_out));
      end else begin
        exp_res = pending_results.pop_front();
        pairs_checked++;
        if (out_item.source_id_out !== exp_res.source_id_out)
          report_mismatch($sformatf("source_id_out %h, want %h",
                                    out_item.source_id_out, exp_res.source_id_out));
        if (out_item.seq_num_out !== exp_res.seq_num_out)
          report_mismatch($sformatf("seq_num_out %h, want %h",
                                    out_item.seq_num_out, exp_res.seq_num_out));
        if (out_item.port_out !== exp_res.port_out)
          report_mismatch($sformatf("port_out %0d, want %0d",
                                    out_item.port_out, exp_res.port_out));
        if (out_item.adjusted_delta !== exp_res.adjusted_delta)
          report_mismatch($sformatf("adjusted_delta %h, want %h",
                                    out_item.adjusted_delta, exp_res.adjusted_delta));
        if (out_item.release_time !== exp_res.release_time)
          report_mismatch($sformatf("release_time %h, want %h",
                                    out_item.release_time, exp_res.release_time));
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    int        begin_pct;

    // Directed rows; the first block runs on the reset delay of zero.
    add_row(begin_row(16'h0000, 32'h0, 48'sd0, 48'd0));
    add_row(paired(end_row(16'h0000, 32'h0, 6'd0, 48'd0), 48'sd0, 48'd0));
    add_row(begin_row(16'hFFFF, 32'hFFFF_FFFF, DELTA_MAX, 48'd0));
    add_row(paired(end_row(16'hFFFF, 32'hFFFF_FFFF, 6'd63, 48'd0), DELTA_MAX, 48'd0));
    add_row(begin_row(16'h0001, 32'h1, DELTA_MIN, 48'd100));
    add_row(paired(end_row(16'h0001, 32'h1, 6'd5, 48'd200), DELTA_MIN, 48'd200));
    // Time going backwards raises the offset past its top.
    add_row(begin_row(16'h0002, 32'h7, DELTA_MAX, TIME_MAX));
    add_row(paired(end_row(16'h0002, 32'h7, 6'd42, 48'd0), DELTA_MAX, 48'd0));
    add_row(end_row(16'h0003, 32'h3, 6'd9, 48'd300));
    // Three identical headers are released oldest first.
    add_row(begin_row(16'h0005, 32'h9, 48'sd1000, 48'd10));
    add_row(begin_row(16'h0005, 32'h9, 48'sd2000, 48'd20));
    add_row(begin_row(16'h0005, 32'h9, 48'sd3000, 48'd30));
    add_row(paired(end_row(16'h0005, 32'h9, 6'd1, 48'd50), 48'sd960, 48'd50));
    add_row(end_row(16'h0005, 32'h9, 6'd2, 48'd50));
    add_row(end_row(16'h0005, 32'h8, 6'd2, 48'd50));
    add_row(end_row(16'h0005, 32'h9, 6'd3, 48'd60));
    add_row(end_row(16'h0005, 32'h9, 6'd3, 48'd60));
    // Release time saturates near the end of the time range.
    add_row(cfg_row(32'd1000));
    add_row(begin_row(16'h0009, 32'h9, 48'sd0, TIME_MAX - 48'd10));
    add_row(paired(end_row(16'h0009, 32'h9, 6'd17, TIME_MAX - 48'd10),
                   -48'sd1000, TIME_MAX));
    add_row(begin_row(16'hABCD, 32'h1234_5678, 48'sd500000, 48'd1000000));
    add_row(end_row(16'hABCD, 32'h1234_5678, 6'd33, 48'd1000400));
    add_row(cfg_row(32'hFFFF_FFFF));
    add_row(begin_row(16'h0004, 32'h4, DELTA_MIN, 48'd0));
    add_row(paired(end_row(16'h0004, 32'h4, 6'd63, 48'd0),
                   DELTA_MIN, 48'h0000_FFFF_FFFF));
    add_row(begin_row(16'h0006, 32'h6, DELTA_MAX, 48'd5));
    add_row(end_row(16'h0006, 32'h6, 6'd0, 48'd5));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_delay(directed_rows[i].cfg_value);
      else send_header(directed_rows[i].item, directed_rows[i].fixed,
                       directed_rows[i].fixed_out);
    end

    // Random phases: the first fills the table, later ones alternate fill and drain.
    timebase = 48'($urandom) << 8;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       write_delay(32'd0);
        1:       write_delay(32'hFFFF_FFFF);
        2:       write_delay(32'($urandom_range(0, 5000)));
        default: write_delay($urandom);
      endcase
      if (p == 0) begin_pct = 90;
      else if (p % 2 == 1) begin_pct = 30;
      else begin_pct = 55;
      tx_gaps_on = (p % 4 != 2);
      rx_stalls_on = (p % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Let the output side empty out completely once in a while.
        if (p % 2 == 1 && n == PHASE_ITEMS / 2) drain_table();
        random_header(begin_pct, it);
        send_header(it, 1'b0, '0);
        sender_pause();
      end
    end

    drain_table();
    $display("Sent %0d begin and %0d end headers; %0d results checked, %0d errors.",
             begins_sent, ends_sent, pairs_checked, error_count);
    $display("Seen %0d begins dropped on a full table, %0d unmatched ends, %0d delay writes.",
             drops_seen, unmatched_seen, delays_written);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #8_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
